@@ hw/rtl/lcps_pkg.sv @@
`timescale 1ns / 1ps

package lcps_pkg;

  // Configuration register indexes
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_ROUNDS_PER_FRAME = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_COUNT    = 1'd1;
  localparam int CFG_DATA_W = 8;

  // Built-in pattern table: three patterns of eight frames
  localparam int ROM_PATTERNS = 3;
  localparam int ROM_FRAMES   = 8;
  localparam int ROM_WORDS    = ROM_PATTERNS * ROM_FRAMES;
  localparam int WORD_W       = 32;
  localparam int MARKER_BIT   = 31;

  localparam logic [WORD_W-1:0] ROM_INIT [ROM_WORDS] = '{
    32'h05555555, 32'h02AAAAAA, 32'h80000000, 32'h80000000,
    32'h00000000, 32'h00000000, 32'h00000000, 32'h00000000,
    32'h00040201, 32'h0028140A, 32'h0150A854, 32'h028140A0,
    32'h04020100, 32'h028140A0, 32'h0150A854, 32'h0028140A,
    32'h00000010, 32'h00007410, 32'h07FD7410, 32'h80000000,
    32'h00000000, 32'h00000000, 32'h00000000, 32'h00000000
  };

  // Reset values of the registers
  localparam logic [7:0] ROUNDS_RESET = 8'd27;
  localparam logic [1:0] PATCNT_RESET = 2'd3;

  // Layer slots
  localparam logic [1:0] SLOT_BOTTOM = 2'd0;
  localparam logic [1:0] SLOT_MIDDLE = 2'd1;
  localparam logic [1:0] SLOT_TOP    = 2'd2;

  typedef enum logic [1:0] {
    ST_FILL,
    ST_PRIME,
    ST_RUN
  } scan_state_t;

  typedef struct packed {
    logic [7:0] column_bits;
    logic       column_nine;
    logic [1:0] layer_select;
    logic [1:0] pattern_shown;
    logic [2:0] frame_shown;
  } result_t;

  // Table word of pattern p, frame f; outside the table it reads as zero
  function automatic logic [WORD_W-1:0] rom_word(input int p, input int f);
    logic [WORD_W-1:0] w;
    w = '0;
    if (p < ROM_PATTERNS && f < ROM_FRAMES) begin
      w = ROM_INIT[p * ROM_FRAMES + f];
    end
    return w;
  endfunction

endpackage

@@ hw/rtl/lcps_if.sv @@
`timescale 1ns / 1ps

// Request channel carrying one layer slot (button sample)
interface lcps_in_if;
  logic valid;
  logic ready;
  logic button_level;

  modport source (output valid, output button_level, input ready);
  modport sink   (input valid, input button_level, output ready);
endinterface

// Result channel carrying the drive of one layer slot
interface lcps_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] column_bits;
  logic       column_nine;
  logic [1:0] layer_select;
  logic [1:0] pattern_shown;
  logic [2:0] frame_shown;

  modport source (output valid, output column_bits, output column_nine,
                  output layer_select, output pattern_shown, output frame_shown,
                  input ready);
  modport sink   (input valid, input column_bits, input column_nine,
                  input layer_select, input pattern_shown, input frame_shown,
                  output ready);
endinterface

@@ hw/rtl/lcps_ram.sv @@
`timescale 1ns / 1ps

// Generic single-write, single-read RAM with registered read data
module lcps_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 8,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

@@ hw/rtl/led_cube_pattern_scanner_top.sv @@
`timescale 1ns / 1ps
// A result is registered on accept, into the skid stage if the output is stalled.
// Throughput: one request per cycle while the skid stage is empty; the frame-row
//   memory is read every cycle at the next frame index, so each slot finds its row
//   already in the read register. Reset: control state clears, then ST_FILL loads
//   the pattern rows and ST_PRIME primes the read; no request is taken until then.
module led_cube_pattern_scanner_top
  import lcps_pkg::*;
#(
  parameter int NUM_PATTERNS       = 3,
  parameter int FRAMES_PER_PATTERN = 8
) (
  input  logic                 clk,
  input  logic                 rst_n,
  lcps_in_if.sink              in_chan,
  lcps_out_if.source           out_chan,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  // Only the patterns the 2-bit count can reach are stored per row
  localparam int PSTORE = (NUM_PATTERNS > 3) ? 3 : NUM_PATTERNS;
  localparam int ROW_W  = PSTORE * WORD_W;
  localparam int FW     = (FRAMES_PER_PATTERN > 1) ? $clog2(FRAMES_PER_PATTERN) : 1;

  // Configuration registers
  logic [7:0] rounds_per_frame_r;
  logic [1:0] pattern_count_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rounds_per_frame_r <= ROUNDS_RESET;
      pattern_count_r    <= PATCNT_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_ROUNDS_PER_FRAME: rounds_per_frame_r <= cfg_data[7:0];
        CFG_PATTERN_COUNT:    pattern_count_r    <= cfg_data[1:0];
        default: ;
      endcase
    end
  end

  // Fill sequencer
  scan_state_t      state_r, state_nxt;
  logic [FW-1:0]    fill_idx_r, fill_idx_nxt;
  logic             ram_we;
  logic [ROW_W-1:0] fill_row;
  logic [ROW_W-1:0] row0_r;
  logic [ROW_W-1:0] rd_row;
  logic [FW-1:0]    frame_r, frame_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_FILL;
      fill_idx_r <= '0;
    end else begin
      state_r    <= state_nxt;
      fill_idx_r <= fill_idx_nxt;
    end
  end

  always_comb begin
    state_nxt    = state_r;
    fill_idx_nxt = fill_idx_r;
    ram_we       = 1'b0;
    case (state_r)
      ST_FILL: begin
        ram_we = 1'b1;
        if (int'(fill_idx_r) == FRAMES_PER_PATTERN - 1) begin
          state_nxt = ST_PRIME;
        end else begin
          fill_idx_nxt = fill_idx_r + 1'b1;
        end
      end
      ST_PRIME: state_nxt = ST_RUN;
      ST_RUN:   state_nxt = ST_RUN;
      default:  state_nxt = ST_FILL;
    endcase
  end

  always_comb begin
    for (int k = 0; k < PSTORE; k++) begin
      fill_row[k*WORD_W +: WORD_W] = rom_word(k, int'(fill_idx_r));
    end
  end

  // Frame zero row kept at hand for the marker restart
  always_ff @(posedge clk) begin
    if (state_r == ST_FILL && fill_idx_r == '0) begin
      row0_r <= fill_row;
    end
  end

  // Read-only after the fill; read address tracks the next frame index
  lcps_ram #(
    .WIDTH (ROW_W),
    .DEPTH (FRAMES_PER_PATTERN),
    .AW    (FW)
  ) u_rows (
    .clk   (clk),
    .we    (ram_we),
    .waddr (fill_idx_r),
    .wdata (fill_row),
    .raddr (frame_nxt),
    .rdata (rd_row)
  );

  // Scan state
  logic [1:0] pattern_r, pattern_nxt;
  logic [1:0] slot_r, slot_nxt;
  logic [7:0] round_r, round_nxt;
  logic       latch_r, latch_nxt;

  // Output register plus skid stage
  result_t out_r, skid_r;
  logic    out_valid_r, skid_full_r;
  logic    accept, out_fire;
  result_t res;

  assign in_chan.ready = (state_r == ST_RUN) && !skid_full_r;
  assign accept        = in_chan.valid && in_chan.ready;
  assign out_fire      = out_valid_r && out_chan.ready;

  logic [1:0]        cnt_eff;
  logic [2:0]        pat_inc;
  logic [1:0]        pat_cur;
  logic [WORD_W-1:0] word_f, word_0, word;
  logic              marker;
  logic [FW-1:0]     frame_cur;
  logic [7:0]        round_cur;
  logic [7:0]        rounds_eff;
  logic [8:0]        round_inc;
  logic [FW:0]       frame_inc;
  logic [7:0]        lay;
  logic [FW+2:0]     frame_ext;

  always_comb begin
    // Effective pattern count: zero acts as one, clamp to the pattern number
    cnt_eff = pattern_count_r;
    if (cnt_eff == 2'd0) cnt_eff = 2'd1;
    if (int'(cnt_eff) > NUM_PATTERNS) cnt_eff = 2'(NUM_PATTERNS);

    // Button rising edge steps the pattern
    pat_inc = {1'b0, pattern_r} + 3'd1;
    pat_cur = pattern_r;
    if (in_chan.button_level && !latch_r) begin
      pat_cur = (pat_inc >= {1'b0, cnt_eff}) ? 2'd0 : pat_inc[1:0];
    end

    // Pick the pattern word from the rows
    word_f = '0;
    word_0 = '0;
    for (int k = 0; k < PSTORE; k++) begin
      if (int'(pat_cur) == k) begin
        word_f = rd_row[k*WORD_W +: WORD_W];
        word_0 = row0_r[k*WORD_W +: WORD_W];
      end
    end

    // Marker word restarts at frame zero in the same slot
    marker    = word_f[MARKER_BIT] && (frame_r != '0);
    word      = marker ? word_0 : word_f;
    frame_cur = marker ? '0 : frame_r;
    round_cur = marker ? 8'd0 : round_r;

    case (slot_r)
      SLOT_BOTTOM: begin
        res.column_nine = word[0];
        lay             = word[8:1];
      end
      SLOT_MIDDLE: begin
        res.column_nine = word[9];
        lay             = word[17:10];
      end
      default: begin
        res.column_nine = word[18];
        lay             = word[26:19];
      end
    endcase
    res.column_bits   = {lay[7:4], lay[2], lay[3], lay[1:0]};
    res.layer_select  = slot_r;
    res.pattern_shown = pat_cur;
    frame_ext         = {3'b000, frame_cur};
    res.frame_shown   = frame_ext[2:0];

    // Slot, round and frame advance
    rounds_eff = (rounds_per_frame_r == 8'd0) ? 8'd1 : rounds_per_frame_r;
    round_inc  = {1'b0, round_cur} + 9'd1;
    frame_inc  = {1'b0, frame_cur} + 1'b1;

    pattern_nxt = pattern_r;
    latch_nxt   = latch_r;
    slot_nxt    = slot_r;
    round_nxt   = round_r;
    frame_nxt   = frame_r;
    if (accept) begin
      pattern_nxt = pat_cur;
      latch_nxt   = in_chan.button_level;
      frame_nxt   = frame_cur;
      round_nxt   = round_cur;
      if (slot_r == SLOT_TOP) begin
        slot_nxt = SLOT_BOTTOM;
        if (round_inc >= {1'b0, rounds_eff}) begin
          round_nxt = 8'd0;
          frame_nxt = (int'(frame_inc) >= FRAMES_PER_PATTERN) ? '0 : frame_inc[FW-1:0];
        end else begin
          round_nxt = round_inc[7:0];
        end
      end else begin
        slot_nxt = slot_r + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pattern_r <= '0;
      latch_r   <= 1'b0;
      slot_r    <= SLOT_BOTTOM;
      round_r   <= '0;
      frame_r   <= '0;
    end else begin
      pattern_r <= pattern_nxt;
      latch_r   <= latch_nxt;
      slot_r    <= slot_nxt;
      round_r   <= round_nxt;
      frame_r   <= frame_nxt;
    end
  end

  // Result buffering: new result goes to the output unless it is stalled
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      skid_full_r <= 1'b0;
    end else if (skid_full_r) begin
      if (out_fire) begin
        skid_full_r <= 1'b0;
      end
    end else if (accept) begin
      if (out_valid_r && !out_fire) begin
        skid_full_r <= 1'b1;
      end else begin
        out_valid_r <= 1'b1;
      end
    end else if (out_fire) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_full_r) begin
      if (out_fire) begin
        out_r <= skid_r;
      end
    end else if (accept) begin
      if (out_valid_r && !out_fire) begin
        skid_r <= res;
      end else begin
        out_r <= res;
      end
    end
  end

  assign out_chan.valid         = out_valid_r;
  assign out_chan.column_bits   = out_r.column_bits;
  assign out_chan.column_nine   = out_r.column_nine;
  assign out_chan.layer_select  = out_r.layer_select;
  assign out_chan.pattern_shown = out_r.pattern_shown;
  assign out_chan.frame_shown   = out_r.frame_shown;

endmodule

@@ hw/rtl/lcps_chk.sv @@
`timescale 1ns / 1ps

// Port-level checks for the scanner
module lcps_chk (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] column_bits,
  input logic       column_nine,
  input logic [1:0] layer_select,
  input logic [1:0] pattern_shown,
  input logic [2:0] frame_shown
);

  // Reset empties the result side and holds off requests during the fill
  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !in_ready)
    else $error("result or ready after reset");

  // A stalled result keeps its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(column_bits)
      && $stable(column_nine) && $stable(layer_select)
      && $stable(pattern_shown) && $stable(frame_shown))
    else $error("stalled result changed");

  // Layer and pattern indexes stay within three values
  a_ranges: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> layer_select != 2'd3 && pattern_shown != 2'd3)
    else $error("layer or pattern index out of range");

  // A request taken while the output stalls fills the skid stage
  a_skid_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready && in_valid && in_ready |=> !in_ready)
    else $error("ready while two results are held");

endmodule

bind led_cube_pattern_scanner_top lcps_chk u_lcps_chk (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_chan.valid),
  .in_ready      (in_chan.ready),
  .out_valid     (out_chan.valid),
  .out_ready     (out_chan.ready),
  .column_bits   (out_chan.column_bits),
  .column_nine   (out_chan.column_nine),
  .layer_select  (out_chan.layer_select),
  .pattern_shown (out_chan.pattern_shown),
  .frame_shown   (out_chan.frame_shown)
);
